FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: design/skt_pkg.sv
package skt_pkg;

  localparam int DefCapacity = 16;

  localparam int FuncW     = 2;
  localparam int KeyW      = 32;
  localparam int AgeW      = 8;
  localparam int ChildrenW = 8;
  localparam int StatusW   = 2;
  localparam int PosW      = 4;
  localparam int CountW    = 5;

  localparam int InDataW  = 56;
  localparam int OutDataW = 16;

  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [AgeW-1:0]        age;
    logic [ChildrenW-1:0]   children;
  } rec_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_item;
    logic    rd_en;
    logic    wr_en;
    logic    wr_new;
    logic    load_out;
    status_e out_status;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic key_eq;
    logic key_lt;
    logic out_free;
  } stat_t;

endpackage

FILE: design/sorted_key_table_core.sv
// Sorted key table: insert, delete and find over a table kept in ascending key order.
// One word at a time. Insert moves up every entry with a larger key, then writes the new one.
// Find scans up from the bottom to the first hit; delete scans down from the top, then moves
// the entries above the hit down. One entry compared or moved per cycle sets the pace.
// Reset clears the entry count and the output valid; the table memory is not cleared.
module sorted_key_table_core
  import skt_pkg::*;
#(
  parameter int CAPACITY = DefCapacity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [1:0] func, [33:2] key, [41:34] age, [49:42] children, rest zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] status, [5:2] position, [10:6] entry_count, rest zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);

  localparam int KeyLo      = FuncW;
  localparam int AgeLo      = KeyLo + KeyW;
  localparam int ChildrenLo = AgeLo + AgeW;

  ctl_t            ctl;
  stat_t           stat;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] pos;
  logic [CntW-1:0] cnt;

  skt_ctrl #(
    .Capacity (CAPACITY),
    .IdxW     (IdxW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tdata[FuncW-1:0]),
    .stat_i     (stat),
    .ctl_o      (ctl),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr),
    .pos_o      (pos),
    .cnt_o      (cnt)
  );

  skt_dpath #(
    .Capacity (CAPACITY),
    .IdxW     (IdxW),
    .CntW     (CntW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .pos_i       (pos),
    .cnt_i       (cnt),
    .key_i       ($signed(s_axis_tdata[KeyLo +: KeyW])),
    .age_i       (s_axis_tdata[AgeLo +: AgeW]),
    .children_i  (s_axis_tdata[ChildrenLo +: ChildrenW]),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

FILE: design/skt_dpath.sv
module skt_dpath
  import skt_pkg::*;
#(
  parameter int Capacity = DefCapacity,
  parameter int IdxW     = $clog2(Capacity),
  parameter int CntW     = $clog2(Capacity + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctl_t                     ctl_i,
  input  logic [IdxW-1:0]          rd_addr_i,
  input  logic [IdxW-1:0]          wr_addr_i,
  input  logic [IdxW-1:0]          pos_i,
  input  logic [CntW-1:0]          cnt_i,
  input  logic signed [KeyW-1:0]   key_i,
  input  logic [AgeW-1:0]          age_i,
  input  logic [ChildrenW-1:0]     children_i,
  output stat_t                    stat_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [OutDataW-1:0]      out_data_o
);

  rec_t mem_q [Capacity];
  rec_t item_q;
  rec_t rd_q;
  rec_t wr_data;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic [IdxW+PosW-1:0]   pos_x;
  logic [CntW+CountW-1:0] cnt_x;

  assign wr_data = ctl_i.wr_new ? item_q : rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
    if (ctl_i.load_item) begin
      item_q <= '{key: key_i, age: age_i, children: children_i};
    end
  end

  assign stat_o.key_eq   = (item_q.key == rd_q.key);
  assign stat_o.key_lt   = ($signed(item_q.key) < $signed(rd_q.key));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // low bits of position and count go out
  assign pos_x = {{PosW{1'b0}}, pos_i};
  assign cnt_x = {{CountW{1'b0}}, cnt_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      out_data_q <= {{(OutDataW - StatusW - PosW - CountW){1'b0}},
                     cnt_x[CountW-1:0], pos_x[PosW-1:0], ctl_i.out_status};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: design/skt_ctrl.sv
`include "assert_macros.svh"

module skt_ctrl
  import skt_pkg::*;
#(
  parameter int Capacity = DefCapacity,
  parameter int IdxW     = $clog2(Capacity),
  parameter int CntW     = $clog2(Capacity + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [FuncW-1:0] func_i,
  input  stat_t            stat_i,
  output ctl_t             ctl_o,
  output logic [IdxW-1:0]  rd_addr_o,
  output logic [IdxW-1:0]  wr_addr_o,
  output logic [IdxW-1:0]  pos_o,
  output logic [CntW-1:0]  cnt_o
);

  localparam int CntXW = CntW + 1;
  localparam logic [CntW-1:0] CntFull = CntW'(Capacity);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS    = 3'd1;
  localparam logic [2:0] S_INS_WR = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DEL    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  func_e           func_q, func_d;
  status_e         status_q, status_d;

  logic [CntXW-1:0] idx_x;
  logic [CntXW-1:0] cnt_x;
  logic [IdxW-1:0]  last_idx;
  logic [IdxW-1:0]  next_idx;
  logic             scan_end;
  logic             accept;

  assign idx_x    = CntXW'(idx_q);
  assign cnt_x    = CntXW'(cnt_q);
  assign last_idx = IdxW'(cnt_q - CntW'(1));
  assign accept   = in_valid_i && in_ready_o;

  // find walks up from the bottom, delete walks down from the top
  assign next_idx = (func_q == FUNC_FIND) ? idx_q + IdxW'(1) : idx_q - IdxW'(1);
  assign scan_end = (func_q == FUNC_FIND) ? (idx_x + CntXW'(1) == cnt_x)
                                          : (idx_q == '0);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    func_d    = func_q;
    status_d  = status_q;
    ctl_o     = '0;
    rd_addr_o = '0;
    wr_addr_o = idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load_item = 1'b1;
          func_d   = func_e'(func_i);
          pos_d    = '0;
          status_d = ST_OK;
          unique case (func_e'(func_i))
            FUNC_INSERT: begin
              if (cnt_q == CntFull) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else if (cnt_q == '0) begin
                idx_d   = '0;
                state_d = S_INS_WR;
              end else begin
                idx_d       = IdxW'(cnt_q);
                ctl_o.rd_en = 1'b1;
                rd_addr_o   = last_idx;
                state_d     = S_INS;
              end
            end
            FUNC_DELETE: begin
              if (cnt_q == '0) begin
                status_d = ST_NOT_FOUND;
                state_d  = S_DONE;
              end else begin
                idx_d       = last_idx;
                ctl_o.rd_en = 1'b1;
                rd_addr_o   = last_idx;
                state_d     = S_SCAN;
              end
            end
            FUNC_FIND: begin
              if (cnt_q == '0) begin
                status_d = ST_NOT_FOUND;
                state_d  = S_DONE;
              end else begin
                idx_d       = '0;
                ctl_o.rd_en = 1'b1;
                rd_addr_o   = '0;
                state_d     = S_SCAN;
              end
            end
            FUNC_NOP: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // read word holds entry idx-1; move it up while the new key is smaller
      S_INS: begin
        ctl_o.wr_en = 1'b1;
        if (stat_i.key_lt) begin
          idx_d = idx_q - IdxW'(1);
          if (idx_q == IdxW'(1)) begin
            state_d = S_INS_WR;
          end else begin
            ctl_o.rd_en = 1'b1;
            rd_addr_o   = idx_q - IdxW'(2);
          end
        end else begin
          ctl_o.wr_new = 1'b1;
          cnt_d   = cnt_q + CntW'(1);
          pos_d   = idx_q;
          state_d = S_DONE;
        end
      end

      S_INS_WR: begin
        ctl_o.wr_en  = 1'b1;
        ctl_o.wr_new = 1'b1;
        cnt_d   = cnt_q + CntW'(1);
        pos_d   = idx_q;
        state_d = S_DONE;
      end

      S_SCAN: begin
        if (stat_i.key_eq) begin
          pos_d = idx_q;
          if (func_q == FUNC_FIND) begin
            state_d = S_DONE;
          end else if (idx_x + CntXW'(1) < cnt_x) begin
            ctl_o.rd_en = 1'b1;
            rd_addr_o   = idx_q + IdxW'(1);
            state_d     = S_DEL;
          end else begin
            cnt_d   = cnt_q - CntW'(1);
            state_d = S_DONE;
          end
        end else if (scan_end) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          idx_d       = next_idx;
          ctl_o.rd_en = 1'b1;
          rd_addr_o   = next_idx;
        end
      end

      // close the gap: entry idx+1 moves down to idx
      S_DEL: begin
        ctl_o.wr_en = 1'b1;
        idx_d = idx_q + IdxW'(1);
        if (idx_x + CntXW'(2) < cnt_x) begin
          ctl_o.rd_en = 1'b1;
          rd_addr_o   = IdxW'(idx_x + CntXW'(2));
        end else begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        ctl_o.out_status = status_q;
        if (stat_i.out_free) begin
          ctl_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      func_q   <= FUNC_NOP;
      status_q <= ST_OK;
      idx_q    <= '0;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      func_q   <= func_d;
      status_q <= status_d;
      idx_q    <= idx_d;
      pos_q    <= pos_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign pos_o      = pos_q;
  assign cnt_o      = cnt_q;

  `ASSERT_HOLDS(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntFull)
  `ASSERT_NEVER(a_no_wr_idle, clk_i, rst_ni, (state_q == S_IDLE) && ctl_o.wr_en)
  `ASSERT_HOLDS(a_accept_busy, clk_i, rst_ni, accept |=> state_q != S_IDLE)
  `ASSERT_HOLDS(a_cnt_moves_at_end, clk_i, rst_ni,
                (cnt_q != $past(cnt_q)) |-> (state_q == S_DONE))

endmodule

FILE: tb/sorted_key_table_core_tb.sv
`timescale 1ns / 100ps

module sorted_key_table_core_tb;
  import skt_pkg::*;

  localparam int Depth      = DefCapacity;
  localparam int NumRandom  = 1275;
  localparam int QuietFrom  = 1100;  // no idling on either side from here on
  localparam int DrainAt    = 400;   // sender waits for every result here
  localparam int HoldAt     = 650;   // receiver holds off for a long stretch here
  localparam int HoldCycles = 300;
  localparam int TailCycles = 80;

  typedef struct packed {
    status_e         status;
    logic [PosW-1:0] position;
    logic [CountW-1:0] count;
  } table_result_t;

  // Mirror of the sorted table; predicts one result word per accepted input word.
  class sorted_table_tracker;
    logic signed [KeyW-1:0] keys [Depth];
    logic [AgeW-1:0]        ages [Depth];
    logic [ChildrenW-1:0]   kids [Depth];
    int                     held;
    table_result_t          pending_results[$];
    int                     errors;

    function void note_word(func_e f, logic signed [KeyW-1:0] key,
                            logic [AgeW-1:0] age, logic [ChildrenW-1:0] nkids);
      table_result_t r;
      int            i;
      int            at;
      bit            hit;
      r.status   = ST_OK;
      r.position = '0;
      hit        = 1'b0;
      at         = 0;
      case (f)
        FUNC_INSERT: begin
          if (held >= Depth) begin
            r.status = ST_FULL;
          end else begin
            i = held;
            // new record lands after any equal keys
            while (i > 0 && key < keys[i-1]) begin
              keys[i] = keys[i-1];
              ages[i] = ages[i-1];
              kids[i] = kids[i-1];
              i--;
            end
            keys[i] = key;
            ages[i] = age;
            kids[i] = nkids;
            held++;
            r.position = i[PosW-1:0];
          end
        end
        FUNC_DELETE: begin
          // last matching entry goes
          for (i = 0; i < held; i++) begin
            if (keys[i] == key) begin
              hit = 1'b1;
              at  = i;
            end
          end
          if (!hit) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (i = at; i + 1 < held; i++) begin
              keys[i] = keys[i+1];
              ages[i] = ages[i+1];
              kids[i] = kids[i+1];
            end
            held--;
            r.position = at[PosW-1:0];
          end
        end
        FUNC_FIND: begin
          for (i = held - 1; i >= 0; i--) begin
            if (keys[i] == key) begin
              hit = 1'b1;
              at  = i;
            end
          end
          if (hit) r.position = at[PosW-1:0];
          else r.status = ST_NOT_FOUND;
        end
        default: ;
      endcase
      r.count = held[CountW-1:0];
      pending_results.push_back(r);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [OutDataW-1:0] word);
      table_result_t want;
      status_e       got_status;
      logic [PosW-1:0]   got_pos;
      logic [CountW-1:0] got_count;
      got_status = status_e'(word[1:0]);
      got_pos    = word[5:2];
      got_count  = word[10:6];
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result word %h", word));
      end else begin
        want = pending_results.pop_front();
        if (got_status != want.status)
          report($sformatf("status %0d, want %0d", got_status, want.status));
        if (got_pos != want.position)
          report($sformatf("position %0d, want %0d", got_pos, want.position));
        if (got_count != want.count)
          report($sformatf("entry_count %0d, want %0d", got_count, want.count));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  logic quiet    = 1'b0;
  logic calm     = 1'b0;
  logic hold_req = 1'b0;

  sorted_table_tracker sb;

  sorted_key_table_core #(.CAPACITY(Depth)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task send_word(func_e f, logic signed [KeyW-1:0] key,
                 logic [AgeW-1:0] age, logic [ChildrenW-1:0] nkids);
    s_axis_tdata  <= {{(InDataW - 50){1'b0}}, nkids, age, key, f};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(f, key, age, nkids);
  endtask

  task sender_gap(int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task wait_drained();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [KeyW-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && sb.held > 0) return sb.keys[$urandom_range(0, sb.held - 1)];
    if (sel < 7) begin
      case ($urandom_range(0, 5))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return -32'sd1;
        3: return 32'sd0;
        default: return $signed(32'($urandom_range(0, 7)) - 32'd3);
      endcase
    end
    return $signed($urandom());
  endfunction

  function automatic func_e pick_func();
    int roll;
    int ins_pct;
    roll    = $urandom_range(0, 99);
    ins_pct = (sb.held < 4) ? 65 : (sb.held > 13) ? 30 : 47;
    if (roll < 3) return FUNC_NOP;
    if (roll < 3 + ins_pct) return FUNC_INSERT;
    if (roll < 3 + ins_pct + (97 - ins_pct) / 2) return FUNC_DELETE;
    return FUNC_FIND;
  endfunction

  // receiver: result checking and output-side stalls
  initial begin : sink
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_req) begin
        stall_left = HoldCycles;
        hold_req  <= 1'b0;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && !calm && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int n;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table
    send_word(FUNC_FIND,   32'sd0, 8'h00, 8'h00);
    send_word(FUNC_DELETE, 32'sd7, 8'hff, 8'hff);
    // fill to capacity: key extremes, payload extremes, runs of equal keys
    send_word(FUNC_INSERT, 32'sd0,          8'h00, 8'hff);
    send_word(FUNC_INSERT, 32'sh7fff_ffff,  8'hff, 8'h00);
    send_word(FUNC_INSERT, 32'sh8000_0000,  8'hff, 8'hff);
    send_word(FUNC_INSERT, -32'sd1,         8'h00, 8'h00);
    send_word(FUNC_INSERT, 32'sd0,          8'h55, 8'haa);
    send_word(FUNC_INSERT, 32'sd5,          8'h01, 8'h02);
    send_word(FUNC_INSERT, 32'sd5,          8'h03, 8'h04);
    send_word(FUNC_INSERT, 32'sd5,          8'h05, 8'h06);
    send_word(FUNC_INSERT, -32'sd100,       8'h80, 8'h7f);
    send_word(FUNC_INSERT, 32'sd1000,       8'h7f, 8'h80);
    send_word(FUNC_INSERT, 32'sd1,          8'h11, 8'h22);
    send_word(FUNC_INSERT, 32'sh8000_0000,  8'h33, 8'h44);
    send_word(FUNC_INSERT, 32'sh7fff_ffff,  8'h66, 8'h77);
    send_word(FUNC_INSERT, 32'sd3,          8'h88, 8'h99);
    send_word(FUNC_INSERT, 32'sh5a5a_a5a5,  8'hcc, 8'hdd);
    send_word(FUNC_INSERT, -32'sh5a5a_a5a5, 8'hee, 8'h0f);
    // table full
    send_word(FUNC_INSERT, 32'sd2,          8'hff, 8'hff);
    send_word(FUNC_FIND,   32'sd5,          8'h00, 8'h00);
    send_word(FUNC_DELETE, 32'sd5,          8'h00, 8'h00);
    send_word(FUNC_DELETE, 32'sd12345,      8'h00, 8'h00);
    send_word(FUNC_FIND,   -32'sd2,         8'h00, 8'h00);
    send_word(FUNC_NOP,    32'sh7fff_ffff,  8'hff, 8'hff);
    send_word(FUNC_DELETE, 32'sh8000_0000,  8'h00, 8'h00);

    for (n = 0; n < NumRandom; n++) begin
      if (n == DrainAt) begin
        sender_gap(0);
        wait_drained();
      end
      if (n == HoldAt) hold_req <= 1'b1;
      if (n == QuietFrom) quiet <= 1'b1;
      if (n % 100 == 0) calm <= ((n / 100) % 3 == 1);
      if (n < QuietFrom && (n / 100) % 3 != 1 && $urandom_range(0, 5) == 0)
        sender_gap($urandom_range(1, 13));
      send_word(pick_func(), pick_key(), 8'($urandom()), 8'($urandom()));
    end
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
